// ===== rtl/f2pcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2pcm_pkg
// Shared types and constants for the float to PCM sample encoder.
// ----------------------------------------------------------------------------
package f2pcm_pkg;

    typedef enum logic [1:0] {
        WIDTH_16 = 2'd0,
        WIDTH_24 = 2'd1,
        WIDTH_32 = 2'd2,
        WIDTH_32_ALT = 2'd3
    } width_code_t;

    localparam logic [7:0] EXP_SAT = 8'd127;
    localparam logic [7:0] EXP_ALL_ONES = 8'hFF;

    // decoded sample fields handed from the input stage to the converter
    typedef struct packed {
        logic        neg;
        logic [7:0]  expo;
        logic [22:0] mant;
    } sample_fields_t;

endpackage

// ===== rtl/f2pcm_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2pcm_convert
// Combinational scale, round, saturate and negate of one float sample.
// ----------------------------------------------------------------------------
module f2pcm_convert
    import f2pcm_pkg::*;
(
    input  sample_fields_t fields,
    input  logic [1:0]     width_code,
    output logic [31:0]    code,
    output logic [2:0]     nbytes
);

    logic [5:0]  w;
    logic [23:0] sig;
    logic [8:0]  e;
    logic [9:0]  s;
    logic [31:0] mag;
    logic [31:0] pos_max;
    logic [31:0] neg_max;
    logic [31:0] mask;
    logic [55:0] wide;
    logic [55:0] rnd;
    logic        nan;
    logic [31:0] neg_code;

    // width decode
    always_comb
    begin
        unique case (width_code_t'(width_code))
            WIDTH_16: w = 6'd16;
            WIDTH_24: w = 6'd24;
            default:  w = 6'd32;
        endcase
    end

    assign nbytes  = w[5:3];
    assign neg_max = 32'd1 << (w - 6'd1);
    assign pos_max = neg_max - 32'd1;
    assign mask    = (w == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);

    // significand and exponent, denormals as exponent one
    assign sig = (fields.expo == 8'd0) ? {1'b0, fields.mant} : {1'b1, fields.mant};
    assign e   = (fields.expo == 8'd0) ? 9'd1 : {1'b0, fields.expo};
    assign nan = (fields.expo == EXP_ALL_ONES) && (fields.mant != 23'd0);

    // right shift amount s = 151 - w - e, only used when expo < 127 (s >= -7)
    assign s = 10'd151 - {4'd0, w} - {1'b0, e};

    // scaled magnitude: left shift by up to 7, or rounded right shift
    always_comb
    begin
        wide = '0;
        rnd  = '0;
        if (sig == 24'd0) begin
            mag = '0;
        end else if (s[9] || s == 10'd0) begin
            wide = {32'd0, sig} << (10'd0 - s);
            mag  = wide[31:0];
        end else if (s >= 10'd26) begin
            mag = '0;
        end else begin
            rnd  = ({32'd0, sig} + (56'd1 << (s - 10'd1))) >> s;
            mag  = rnd[31:0];
        end
    end

    // saturate and form the two's complement code
    always_comb
    begin
        logic [31:0] m;
        m = '0;
        if (nan) begin
            m = '0;
        end else if (fields.expo >= EXP_SAT) begin
            m = fields.neg ? neg_max : pos_max;
        end else if (fields.neg) begin
            m = (mag > neg_max) ? neg_max : mag;
        end else begin
            m = (mag > pos_max) ? pos_max : mag;
        end
        neg_code = (32'd0 - m) & mask;
        code = fields.neg ? neg_code : (m & mask);
    end

endmodule

// ===== rtl/float_to_pcm_sample_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_to_pcm_sample_encoder
// Registers: input register, then result register, with the conversion between them.
// Throughput: one sample per clock while out_stall is low; conversion is one combinational pass.
// Output stage stalls ripple back through the input register as a pipeline.
// Reset clears valid flags and sets the width register to 16-bit.
// ----------------------------------------------------------------------------
module float_to_pcm_sample_encoder
    import f2pcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pcm_code,
    output logic [2:0]  byte_count
);

    logic [1:0]     width_reg;
    logic           s1_valid_reg;
    logic [31:0]    s1_bits_reg;
    logic           s2_valid_reg;
    logic [31:0]    code_reg;
    logic [2:0]     nbytes_reg;
    logic           s2_adv;
    logic           s1_adv;
    sample_fields_t fields;
    logic [31:0]    code_next;
    logic [2:0]     nbytes_next;

    assign cfg_ready = 1'b1;

    // width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg <= WIDTH_16;
        end else if (cfg_valid && cfg_ready) begin
            width_reg <= cfg_data;
        end
    end

    // pipeline flow control
    assign s2_adv   = !s2_valid_reg || !out_stall;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_stall = !s1_adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid) begin
            s1_bits_reg <= sample_bits;
        end
    end

    assign fields = '{neg: s1_bits_reg[31], expo: s1_bits_reg[30:23],
                      mant: s1_bits_reg[22:0]};

    f2pcm_convert u_convert (
        .fields     (fields),
        .width_code (width_reg),
        .code       (code_next),
        .nbytes     (nbytes_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_valid_reg) begin
            code_reg   <= code_next;
            nbytes_reg <= nbytes_next;
        end
    end

    assign out_valid  = s2_valid_reg;
    assign pcm_code   = code_reg;
    assign byte_count = nbytes_reg;

    // a stalled result is not lost or replaced
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pcm_code))
        else $error("result changed while stalled");

    // byte count matches a legal width
    a_nbytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count == 3'd2 || byte_count == 3'd3 || byte_count == 3'd4))
        else $error("bad byte count");

    // input transfer moves into the input register
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_valid_reg)
        else $error("accepted sample dropped");

endmodule
